[sv/msq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types, constants and the per-case primitive table of the marching
// squares cell mesher.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int MSQ_MAX_DIM = 1024;
  localparam int DIM_W       = 11;
  localparam int IDX_W       = 22;
  localparam int COORD_W     = 10;
  localparam int SAMPLE_W    = 16;

  localparam logic [10:0] GRID_RESET = 11'd64;

  // register indexes on the config port
  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  // primitive kinds
  localparam logic PRIM_TRI  = 1'b0;
  localparam logic PRIM_LINE = 1'b1;

  // cell vertices: corners V_TL, V_TR, V_BL, V_BR, then edge midpoints V_T, V_B, V_L, V_R
  typedef enum logic [2:0] {
    V_TL = 3'd0,
    V_TR = 3'd1,
    V_BL = 3'd2,
    V_BR = 3'd3,
    V_T  = 3'd4,
    V_B  = 3'd5,
    V_L  = 3'd6,
    V_R  = 3'd7
  } vsel_t;

  typedef struct packed {
    logic  kind;
    vsel_t v0;
    vsel_t v1;
    vsel_t v2;
  } prim_t;

  function automatic prim_t mk(input logic kind, input vsel_t a, input vsel_t b,
                               input vsel_t c);
    prim_t p;
    p.kind = kind;
    p.v0   = a;
    p.v1   = b;
    p.v2   = c;
    return p;
  endfunction

  // number of primitives a case emits
  function automatic logic [2:0] mesh_count(input logic [3:0] c);
    logic [2:0] n;
    unique case (c)
      4'd0:                          n = 3'd0;
      4'd1, 4'd2, 4'd4, 4'd8, 4'd15: n = 3'd2;
      4'd3, 4'd5, 4'd10, 4'd12:      n = 3'd3;
      default:                       n = 3'd4;
    endcase
    return n;
  endfunction

  // primitive k of case c; line entries leave the third vertex unused
  function automatic prim_t mesh_prim(input logic [3:0] c, input logic [1:0] k);
    prim_t p;
    unique case ({c, k})
      {4'd1, 2'd0}:  p = mk(PRIM_TRI,  V_TL, V_T,  V_L);
      {4'd1, 2'd1}:  p = mk(PRIM_LINE, V_L,  V_T,  V_TL);
      {4'd2, 2'd0}:  p = mk(PRIM_TRI,  V_T,  V_TR, V_R);
      {4'd2, 2'd1}:  p = mk(PRIM_LINE, V_T,  V_R,  V_TL);
      {4'd3, 2'd0}:  p = mk(PRIM_TRI,  V_TL, V_TR, V_R);
      {4'd3, 2'd1}:  p = mk(PRIM_TRI,  V_TL, V_R,  V_L);
      {4'd3, 2'd2}:  p = mk(PRIM_LINE, V_L,  V_R,  V_TL);
      {4'd4, 2'd0}:  p = mk(PRIM_TRI,  V_BL, V_L,  V_B);
      {4'd4, 2'd1}:  p = mk(PRIM_LINE, V_B,  V_L,  V_TL);
      {4'd5, 2'd0}:  p = mk(PRIM_TRI,  V_TL, V_T,  V_B);
      {4'd5, 2'd1}:  p = mk(PRIM_TRI,  V_TL, V_B,  V_BL);
      {4'd5, 2'd2}:  p = mk(PRIM_LINE, V_B,  V_T,  V_TL);
      {4'd6, 2'd0}:  p = mk(PRIM_TRI,  V_BL, V_L,  V_B);
      {4'd6, 2'd1}:  p = mk(PRIM_TRI,  V_T,  V_TR, V_R);
      {4'd6, 2'd2}:  p = mk(PRIM_LINE, V_B,  V_L,  V_TL);
      {4'd6, 2'd3}:  p = mk(PRIM_LINE, V_T,  V_R,  V_TL);
      {4'd7, 2'd0}:  p = mk(PRIM_TRI,  V_TL, V_TR, V_R);
      {4'd7, 2'd1}:  p = mk(PRIM_TRI,  V_TL, V_R,  V_B);
      {4'd7, 2'd2}:  p = mk(PRIM_TRI,  V_TL, V_B,  V_BL);
      {4'd7, 2'd3}:  p = mk(PRIM_LINE, V_B,  V_R,  V_TL);
      {4'd8, 2'd0}:  p = mk(PRIM_TRI,  V_R,  V_BR, V_B);
      {4'd8, 2'd1}:  p = mk(PRIM_LINE, V_R,  V_B,  V_TL);
      {4'd9, 2'd0}:  p = mk(PRIM_TRI,  V_R,  V_BR, V_B);
      {4'd9, 2'd1}:  p = mk(PRIM_TRI,  V_L,  V_TL, V_T);
      {4'd9, 2'd2}:  p = mk(PRIM_LINE, V_L,  V_T,  V_TL);
      {4'd9, 2'd3}:  p = mk(PRIM_LINE, V_R,  V_B,  V_TL);
      {4'd10, 2'd0}: p = mk(PRIM_TRI,  V_T,  V_TR, V_BR);
      {4'd10, 2'd1}: p = mk(PRIM_TRI,  V_T,  V_BR, V_B);
      {4'd10, 2'd2}: p = mk(PRIM_LINE, V_T,  V_B,  V_TL);
      {4'd11, 2'd0}: p = mk(PRIM_TRI,  V_TL, V_TR, V_BR);
      {4'd11, 2'd1}: p = mk(PRIM_TRI,  V_TL, V_BR, V_B);
      {4'd11, 2'd2}: p = mk(PRIM_TRI,  V_TL, V_B,  V_L);
      {4'd11, 2'd3}: p = mk(PRIM_LINE, V_L,  V_B,  V_TL);
      {4'd12, 2'd0}: p = mk(PRIM_TRI,  V_L,  V_R,  V_BR);
      {4'd12, 2'd1}: p = mk(PRIM_TRI,  V_L,  V_BR, V_BL);
      {4'd12, 2'd2}: p = mk(PRIM_LINE, V_R,  V_L,  V_TL);
      {4'd13, 2'd0}: p = mk(PRIM_TRI,  V_TL, V_T,  V_R);
      {4'd13, 2'd1}: p = mk(PRIM_TRI,  V_TL, V_R,  V_BR);
      {4'd13, 2'd2}: p = mk(PRIM_TRI,  V_TL, V_BR, V_BL);
      {4'd13, 2'd3}: p = mk(PRIM_LINE, V_R,  V_T,  V_TL);
      {4'd14, 2'd0}: p = mk(PRIM_TRI,  V_T,  V_TR, V_BR);
      {4'd14, 2'd1}: p = mk(PRIM_TRI,  V_T,  V_BR, V_BL);
      {4'd14, 2'd2}: p = mk(PRIM_TRI,  V_T,  V_BL, V_L);
      {4'd14, 2'd3}: p = mk(PRIM_LINE, V_T,  V_L,  V_TL);
      {4'd15, 2'd0}: p = mk(PRIM_TRI,  V_TL, V_TR, V_BR);
      {4'd15, 2'd1}: p = mk(PRIM_TRI,  V_TL, V_BR, V_BL);
      default:       p = mk(PRIM_TRI,  V_TL, V_TL, V_TL);
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[sv/marching_squares_cell_mesher_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// marching_squares_cell_mesher_unit
// Classifies one grid cell by its corner signs and emits the filled triangles
// and border lines of that case as global vertex indices.
// ----------------------------------------------------------------------------
// Usage:
//   A cell word (coordinates and four corner samples) is taken at a rising
//   edge where start is high and busy is low. Each primitive appears on the
//   result ports for one cycle with result_valid high; last_of_cell marks the
//   final primitive of a cell. The receiver cannot stall the results.
//   A word passes four register stages, then the output register, before
//   its first primitive shows. The emit stage hands out one primitive a
//   cycle and holds a cell until it hands out its last primitive; an empty
//   cell emits nothing. Words can be taken every cycle while the emit stage
//   keeps up; busy rises while it is still working on a cell.
//   Grid size comes from grid_columns and grid_rows on the APB port; the
//   user must write them only while the block is idle, which the block does
//   not enforce. Both reset to 64 and are clamped to 2..MAX_DIM when used.
//   Reset empties the pipeline at once.
// ----------------------------------------------------------------------------
module marching_squares_cell_mesher_unit
  import msq_pkg::*;
#(
  parameter int MAX_DIM = MSQ_MAX_DIM
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // config port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // cell word
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [COORD_W-1:0]         cell_x,
  input  wire logic [COORD_W-1:0]         cell_y,
  input  wire logic signed [SAMPLE_W-1:0] sample_top_left,
  input  wire logic signed [SAMPLE_W-1:0] sample_top_right,
  input  wire logic signed [SAMPLE_W-1:0] sample_bottom_left,
  input  wire logic signed [SAMPLE_W-1:0] sample_bottom_right,
  // primitives
  output logic                            result_valid,
  output logic                            prim_kind,
  output logic [IDX_W-1:0]                vertex_first,
  output logic [IDX_W-1:0]                vertex_second,
  output logic [IDX_W-1:0]                vertex_third,
  output logic [3:0]                      cell_case,
  output logic                            last_of_cell
);

  // config registers
  logic [DIM_W-1:0] grid_columns;
  logic [DIM_W-1:0] grid_rows;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= GRID_RESET;
      grid_rows    <= GRID_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_GRID_COLUMNS: grid_columns <= pwdata[DIM_W-1:0];
        REG_GRID_ROWS:    grid_rows    <= pwdata[DIM_W-1:0];
        default:          grid_columns <= grid_columns;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_ROWS: prdata = {{(32-DIM_W){1'b0}}, grid_rows};
      default:       prdata = {{(32-DIM_W){1'b0}}, grid_columns};
    endcase
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(2)) begin
      r = DIM_W'(2);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // grid-derived constants, registered behind the grid size registers
  logic [DIM_W-1:0] dim_x;
  logic [DIM_W-1:0] dim_y;
  logic [DIM_W-1:0] dim_xm1;
  logic [IDX_W-1:0] node_count;
  logic [IDX_W-1:0] vert_base;   // nodes plus horizontal edges

  always_ff @(posedge clk) begin
    dim_x      <= clamp_dim(grid_columns);
    dim_y      <= clamp_dim(grid_rows);
    dim_xm1    <= clamp_dim(grid_columns) - DIM_W'(1);
    node_count <= IDX_W'(dim_x) * IDX_W'(dim_y);
    vert_base  <= IDX_W'(dim_y) * (IDX_W'(dim_x) + IDX_W'(dim_xm1));
  end

  logic adv;

  // stage 1: classify, register coordinates
  logic               s1_valid;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic [3:0]         s1_case;

  // a sample counts as positive when strictly above zero
  function automatic logic pos(input logic signed [SAMPLE_W-1:0] s);
    return !s[SAMPLE_W-1] && (s != '0);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= start;
    end
    if (adv) begin
      s1_x    <= cell_x;
      s1_y    <= cell_y;
      s1_case <= {pos(sample_bottom_right), pos(sample_bottom_left),
                  pos(sample_top_right), pos(sample_top_left)};
    end
  end

  // stage 2: row products
  logic               s2_valid;
  logic [COORD_W-1:0] s2_x;
  logic [3:0]         s2_case;
  logic [IDX_W-1:0]   s2_yx;
  logic [IDX_W-1:0]   s2_yxm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_x    <= s1_x;
      s2_case <= s1_case;
      s2_yx   <= IDX_W'(s1_y) * IDX_W'(dim_x);
      s2_yxm  <= IDX_W'(s1_y) * IDX_W'(dim_xm1);
    end
  end

  // stage 3: base indices of top-left node, top edge, left edge
  logic             s3_valid;
  logic [3:0]       s3_case;
  logic [IDX_W-1:0] s3_tl;
  logic [IDX_W-1:0] s3_t;
  logic [IDX_W-1:0] s3_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
    if (adv) begin
      s3_case <= s2_case;
      s3_tl   <= IDX_W'(s2_x) + s2_yx;
      s3_t    <= node_count + IDX_W'(s2_x) + s2_yxm;
      s3_l    <= vert_base + IDX_W'(s2_x) + s2_yx;
    end
  end

  // stage 4: all eight indices, held while the cell's primitives go out
  logic             s4_valid;
  logic [3:0]       s4_case;
  logic [IDX_W-1:0] s4_vidx [8];
  logic [1:0]       s4_lastk;
  logic             s4_empty;
  logic [1:0]       s4_k;
  logic [2:0]       s3_count;
  logic             s4_done;

  assign s3_count = mesh_count(s3_case);
  assign s4_done  = s4_empty || (s4_k == s4_lastk);
  assign adv      = !s4_valid || s4_done;
  assign busy     = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s4_k     <= 2'd0;
    end else if (adv) begin
      s4_valid <= s3_valid;
      s4_k     <= 2'd0;
    end else begin
      s4_k <= s4_k + 2'd1;
    end
    if (adv) begin
      s4_case       <= s3_case;
      s4_empty      <= (s3_count == 3'd0);
      s4_lastk      <= 2'(s3_count - 3'd1);
      s4_vidx[V_TL] <= s3_tl;
      s4_vidx[V_TR] <= s3_tl + IDX_W'(1);
      s4_vidx[V_BL] <= s3_tl + IDX_W'(dim_x);
      s4_vidx[V_BR] <= s3_tl + IDX_W'(dim_x) + IDX_W'(1);
      s4_vidx[V_T]  <= s3_t;
      s4_vidx[V_B]  <= s3_t + IDX_W'(dim_xm1);
      s4_vidx[V_L]  <= s3_l;
      s4_vidx[V_R]  <= s3_l + IDX_W'(1);
    end
  end

  // output register
  prim_t prim;

  assign prim = mesh_prim(s4_case, s4_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s4_valid && !s4_empty;
    end
    prim_kind     <= prim.kind;
    vertex_first  <= s4_vidx[prim.v0];
    vertex_second <= s4_vidx[prim.v1];
    vertex_third  <= (prim.kind == PRIM_LINE) ? '0 : s4_vidx[prim.v2];
    cell_case     <= s4_case;
    last_of_cell  <= (s4_k == s4_lastk);
  end

  // checks
  a_no_result_without_cell: assert property (@(posedge clk) disable iff (rst)
    !s4_valid |=> !result_valid)
    else $error("result strobe without a cell in the emit stage");

  a_line_third_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (prim_kind == PRIM_LINE) |-> (vertex_third == '0))
    else $error("border line with nonzero third vertex");

  a_cell_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_cell |=> result_valid && $stable(cell_case))
    else $error("primitives of one cell not back to back");

  a_empty_case_silent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (cell_case != 4'd0))
    else $error("empty case produced a primitive");

endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the marching squares cell mesher. Cell words go in
// through start/busy from a queue of pending cells. Each accepted cell is run
// through a local mesher model that pushes the expected primitives. A monitor
// compares every strobed primitive with the oldest expected one. The grid size
// is changed over the APB port between phases, covering the extremes and the
// clamped values.
// ----------------------------------------------------------------------------
module testbench
  import msq_pkg::*;
();

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_LIMIT = 20;

  typedef struct {
    logic [COORD_W-1:0]         x;
    logic [COORD_W-1:0]         y;
    logic signed [SAMPLE_W-1:0] s_tl;
    logic signed [SAMPLE_W-1:0] s_tr;
    logic signed [SAMPLE_W-1:0] s_bl;
    logic signed [SAMPLE_W-1:0] s_br;
  } cell_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] v1;
    logic [IDX_W-1:0] v2;
    logic [IDX_W-1:0] v3;
    logic [3:0]       cls;
    logic             last;
  } prim_rec_t;

  typedef struct packed {
    logic [2:0]     n;
    prim_t [3:0]    p;
  } case_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                       start = 1'b0;
  logic                       busy;
  logic [COORD_W-1:0]         cell_x = '0;
  logic [COORD_W-1:0]         cell_y = '0;
  logic signed [SAMPLE_W-1:0] sample_top_left = '0;
  logic signed [SAMPLE_W-1:0] sample_top_right = '0;
  logic signed [SAMPLE_W-1:0] sample_bottom_left = '0;
  logic signed [SAMPLE_W-1:0] sample_bottom_right = '0;

  logic             result_valid;
  logic             prim_kind;
  logic [IDX_W-1:0] vertex_first;
  logic [IDX_W-1:0] vertex_second;
  logic [IDX_W-1:0] vertex_third;
  logic [3:0]       cell_case;
  logic             last_of_cell;

  marching_squares_cell_mesher_unit dut (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .start               (start),
    .busy                (busy),
    .cell_x              (cell_x),
    .cell_y              (cell_y),
    .sample_top_left     (sample_top_left),
    .sample_top_right    (sample_top_right),
    .sample_bottom_left  (sample_bottom_left),
    .sample_bottom_right (sample_bottom_right),
    .result_valid        (result_valid),
    .prim_kind           (prim_kind),
    .vertex_first        (vertex_first),
    .vertex_second       (vertex_second),
    .vertex_third        (vertex_third),
    .cell_case           (cell_case),
    .last_of_cell        (last_of_cell)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // local copy of the grid size registers
  logic [DIM_W-1:0] grid_cols = GRID_RESET;
  logic [DIM_W-1:0] grid_rows = GRID_RESET;

  cell_t     cells_pending[$];
  prim_rec_t prims_expected[$];
  cell_t     cur_cell;
  int        cells_sent = 0;
  int        cells_taken = 0;
  int        prims_seen = 0;
  int        settings_used = 1;
  int        errors = 0;
  int        gap_pct = 17;
  int        quiet = 0;
  logic [15:0] cases_hit = '0;

  function automatic prim_t tri_p(input vsel_t a, input vsel_t b, input vsel_t c);
    prim_t p;
    p.kind = PRIM_TRI;
    p.v0 = a;
    p.v1 = b;
    p.v2 = c;
    return p;
  endfunction

  function automatic prim_t seg_p(input vsel_t a, input vsel_t b);
    prim_t p;
    p.kind = PRIM_LINE;
    p.v0 = a;
    p.v1 = b;
    p.v2 = V_TL;
    return p;
  endfunction

  // triangles first, then border lines; ambiguous cases split into corners
  function automatic case_row_t case_row(input logic [3:0] c);
    case_row_t r;
    r = '0;
    case (c)
      4'd1: begin
        r.n = 3'd2;
        r.p[0] = tri_p(V_TL, V_T, V_L);
        r.p[1] = seg_p(V_L, V_T);
      end
      4'd2: begin
        r.n = 3'd2;
        r.p[0] = tri_p(V_T, V_TR, V_R);
        r.p[1] = seg_p(V_T, V_R);
      end
      4'd3: begin
        r.n = 3'd3;
        r.p[0] = tri_p(V_TL, V_TR, V_R);
        r.p[1] = tri_p(V_TL, V_R, V_L);
        r.p[2] = seg_p(V_L, V_R);
      end
      4'd4: begin
        r.n = 3'd2;
        r.p[0] = tri_p(V_BL, V_L, V_B);
        r.p[1] = seg_p(V_B, V_L);
      end
      4'd5: begin
        r.n = 3'd3;
        r.p[0] = tri_p(V_TL, V_T, V_B);
        r.p[1] = tri_p(V_TL, V_B, V_BL);
        r.p[2] = seg_p(V_B, V_T);
      end
      4'd6: begin
        r.n = 3'd4;
        r.p[0] = tri_p(V_BL, V_L, V_B);
        r.p[1] = tri_p(V_T, V_TR, V_R);
        r.p[2] = seg_p(V_B, V_L);
        r.p[3] = seg_p(V_T, V_R);
      end
      4'd7: begin
        r.n = 3'd4;
        r.p[0] = tri_p(V_TL, V_TR, V_R);
        r.p[1] = tri_p(V_TL, V_R, V_B);
        r.p[2] = tri_p(V_TL, V_B, V_BL);
        r.p[3] = seg_p(V_B, V_R);
      end
      4'd8: begin
        r.n = 3'd2;
        r.p[0] = tri_p(V_R, V_BR, V_B);
        r.p[1] = seg_p(V_R, V_B);
      end
      4'd9: begin
        r.n = 3'd4;
        r.p[0] = tri_p(V_R, V_BR, V_B);
        r.p[1] = tri_p(V_L, V_TL, V_T);
        r.p[2] = seg_p(V_L, V_T);
        r.p[3] = seg_p(V_R, V_B);
      end
      4'd10: begin
        r.n = 3'd3;
        r.p[0] = tri_p(V_T, V_TR, V_BR);
        r.p[1] = tri_p(V_T, V_BR, V_B);
        r.p[2] = seg_p(V_T, V_B);
      end
      4'd11: begin
        r.n = 3'd4;
        r.p[0] = tri_p(V_TL, V_TR, V_BR);
        r.p[1] = tri_p(V_TL, V_BR, V_B);
        r.p[2] = tri_p(V_TL, V_B, V_L);
        r.p[3] = seg_p(V_L, V_B);
      end
      4'd12: begin
        r.n = 3'd3;
        r.p[0] = tri_p(V_L, V_R, V_BR);
        r.p[1] = tri_p(V_L, V_BR, V_BL);
        r.p[2] = seg_p(V_R, V_L);
      end
      4'd13: begin
        r.n = 3'd4;
        r.p[0] = tri_p(V_TL, V_T, V_R);
        r.p[1] = tri_p(V_TL, V_R, V_BR);
        r.p[2] = tri_p(V_TL, V_BR, V_BL);
        r.p[3] = seg_p(V_R, V_T);
      end
      4'd14: begin
        r.n = 3'd4;
        r.p[0] = tri_p(V_T, V_TR, V_BR);
        r.p[1] = tri_p(V_T, V_BR, V_BL);
        r.p[2] = tri_p(V_T, V_BL, V_L);
        r.p[3] = seg_p(V_T, V_L);
      end
      4'd15: begin
        r.n = 3'd2;
        r.p[0] = tri_p(V_TL, V_TR, V_BR);
        r.p[1] = tri_p(V_TL, V_BR, V_BL);
      end
      default: r.n = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v < 2) return 32'd2;
    if (v > MSQ_MAX_DIM) return 32'(MSQ_MAX_DIM);
    return {21'd0, v};
  endfunction

  function automatic logic is_pos(input logic signed [SAMPLE_W-1:0] s);
    return !s[SAMPLE_W-1] && (s != 0);
  endfunction

  // mesh one cell and queue its primitives
  function automatic void mesh_cell(input cell_t c);
    logic [31:0] gx, gy, nodes, hor, xx, yy;
    logic [31:0] vid [8];
    logic [3:0]  cls;
    case_row_t   row;
    prim_rec_t   r;
    gx = clamp_dim(grid_cols);
    gy = clamp_dim(grid_rows);
    xx = {22'd0, c.x};
    yy = {22'd0, c.y};
    nodes = gx * gy;
    hor = gy * (gx - 1);
    cls = {is_pos(c.s_br), is_pos(c.s_bl), is_pos(c.s_tr), is_pos(c.s_tl)};
    vid[V_TL] = xx + yy * gx;
    vid[V_TR] = xx + 1 + yy * gx;
    vid[V_BL] = xx + (yy + 1) * gx;
    vid[V_BR] = xx + 1 + (yy + 1) * gx;
    vid[V_T]  = nodes + xx + yy * (gx - 1);
    vid[V_B]  = nodes + xx + (yy + 1) * (gx - 1);
    vid[V_L]  = nodes + hor + xx + yy * gx;
    vid[V_R]  = nodes + hor + xx + 1 + yy * gx;
    row = case_row(cls);
    for (int k = 0; k < row.n; k++) begin
      r.kind = row.p[k].kind;
      r.v1 = vid[row.p[k].v0][IDX_W-1:0];
      r.v2 = vid[row.p[k].v1][IDX_W-1:0];
      r.v3 = (row.p[k].kind == PRIM_LINE) ? '0 : vid[row.p[k].v2][IDX_W-1:0];
      r.cls = cls;
      r.last = (k == row.n - 1);
      prims_expected = {prims_expected, r};
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      7: return 16'sh0000;
      8: return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh0001;
      9: return ($urandom_range(1) != 0) ? 16'sh8000 : 16'shFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // near-zero and full-scale samples on either side of the threshold, and 0x1000 against -1
  function automatic logic signed [SAMPLE_W-1:0] edge_sample(input logic pos, input int k);
    case (k % 3)
      0: return pos ? 16'sh0001 : 16'sh0000;
      1: return pos ? 16'sh7FFF : 16'sh8000;
      default: return pos ? 16'sh1000 : 16'shFFFF;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    logic [31:0] gx, gy;
    gx = clamp_dim(grid_cols);
    gy = clamp_dim(grid_rows);
    // mostly cells inside the grid, a few anywhere in the coordinate range
    if ($urandom_range(9) == 0) begin
      c.x = COORD_W'($urandom);
      c.y = COORD_W'($urandom);
    end else begin
      c.x = COORD_W'($urandom_range(gx - 2, 0));
      c.y = COORD_W'($urandom_range(gy - 2, 0));
    end
    c.s_tl = rand_sample();
    c.s_tr = rand_sample();
    c.s_bl = rand_sample();
    c.s_br = rand_sample();
    return c;
  endfunction

  task automatic push_cell(input cell_t c);
    cells_pending = {cells_pending, c};
    cells_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_GRID_COLUMNS) grid_cols = value[DIM_W-1:0];
    else grid_rows = value[DIM_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait for every cell to be taken and every primitive to come out
  task automatic settle();
    while (cells_taken != cells_sent || prims_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] cols, input logic [31:0] rows,
                           input int n, input int gaps);
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_GRID_ROWS, rows);
    settings_used++;
    gap_pct = gaps;
    for (int i = 0; i < n; i++) push_cell(rand_cell());
    settle();
  endtask

  // driver: one cell word per start/busy handshake
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        mesh_cell(cur_cell);
        cells_taken++;
      end
      if (start && busy) begin
        // hold the word until it is taken
      end else if (cells_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cur_cell = cells_pending.pop_front();
        start <= 1'b1;
        cell_x <= cur_cell.x;
        cell_y <= cur_cell.y;
        sample_top_left <= cur_cell.s_tl;
        sample_top_right <= cur_cell.s_tr;
        sample_bottom_left <= cur_cell.s_bl;
        sample_bottom_right <= cur_cell.s_br;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be stalled, so every strobe is checked
  always @(posedge clk) begin
    prim_rec_t want;
    if (!rst && result_valid) begin
      prims_seen++;
      cases_hit[cell_case] = 1'b1;
      if (prims_expected.size() == 0) begin
        report_mismatch("unexpected primitive, case", {28'd0, cell_case}, 32'd0);
      end else begin
        want = prims_expected.pop_front();
        if (prim_kind !== want.kind)
          report_mismatch("prim_kind", 32'(prim_kind), 32'(want.kind));
        if (vertex_first !== want.v1)
          report_mismatch("vertex_first", 32'(vertex_first), 32'(want.v1));
        if (vertex_second !== want.v2)
          report_mismatch("vertex_second", 32'(vertex_second), 32'(want.v2));
        if (vertex_third !== want.v3)
          report_mismatch("vertex_third", 32'(vertex_third), 32'(want.v3));
        if (cell_case !== want.cls)
          report_mismatch("cell_case", 32'(cell_case), 32'(want.cls));
        if (last_of_cell !== want.last)
          report_mismatch("last_of_cell", 32'(last_of_cell), 32'(want.last));
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || psel) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: %0d cells sent, %0d taken, %0d primitives outstanding",
                 cells_sent, cells_taken, prims_expected.size());
        $display("[marching_squares_cell_mesher_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    cell_t c;
    int    coord_pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: every case at reset grid size, corner cells and outside cells
    for (int k = 0; k < 16; k++) begin
      coord_pick = k % 5;
      case (coord_pick)
        0: begin c.x = 10'd0; c.y = 10'd0; end
        1: begin c.x = 10'd62; c.y = 10'd62; end
        2: begin c.x = 10'd1023; c.y = 10'd1023; end
        3: begin c.x = 10'd1023; c.y = 10'd0; end
        default: begin c.x = 10'd0; c.y = 10'd1023; end
      endcase
      c.s_tl = edge_sample(k[0], k);
      c.s_tr = edge_sample(k[1], k + 1);
      c.s_bl = edge_sample(k[2], k + 2);
      c.s_br = edge_sample(k[3], k);
      push_cell(c);
    end
    c.x = 10'd5;
    c.y = 10'd7;
    c.s_tl = 16'sh8000; c.s_tr = 16'sh8000; c.s_bl = 16'sh8000; c.s_br = 16'sh8000;
    push_cell(c);
    c.s_tl = 16'sh0000; c.s_tr = 16'sh0000; c.s_bl = 16'sh0000; c.s_br = 16'sh0000;
    push_cell(c);
    c.s_tl = 16'sh7FFF; c.s_tr = 16'sh7FFF; c.s_bl = 16'sh7FFF; c.s_br = 16'sh7FFF;
    push_cell(c);
    c.x = 10'h2AA;
    c.y = 10'h155;
    c.s_tl = 16'sh5555; c.s_tr = 16'shAAAA; c.s_bl = 16'shAAAA; c.s_br = 16'sh5555;
    push_cell(c);
    settle();

    run_phase(32'd2, 32'd2, 64, 17);
    // largest grid, driven back to back
    run_phase(32'd1024, 32'd1024, 64, 0);
    // below range clamps up to two
    run_phase(32'd0, 32'd1, 64, 17);
    // above range clamps down to the maximum
    run_phase(32'd2047, 32'd1025, 64, 17);
    // bits above the register width are dropped
    run_phase(32'hFFFF_F805, 32'hFFFF_0010, 64, 17);
    run_phase($urandom_range(1024, 2), $urandom_range(1024, 2), 64, 17);
    run_phase(32'd3, 32'd1000, 64, 17);

    $display("%0d cells taken over %0d grid settings, %0d primitives checked",
             cells_taken, settings_used, prims_seen);
    $display("cell cases seen on the output: %b", cases_hit);
    if (errors == 0) begin
      $display("[marching_squares_cell_mesher_unit] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[marching_squares_cell_mesher_unit] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/msq_pkg.sv
sv/marching_squares_cell_mesher_unit.sv
verif/testbench.sv
